[sv/beat_clock_quantizer_assert.svh]
// Assertion macros for the checker file of the beat clock quantizer.
`ifndef BEAT_CLOCK_QUANTIZER_ASSERT_SVH
`define BEAT_CLOCK_QUANTIZER_ASSERT_SVH

// Checked while the block is out of reset.
`define BCQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BCQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/bcq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_pkg
// Request codes, state codes and fixed constants of the beat clock quantizer.
// ----------------------------------------------------------------------------
package bcq_pkg;

  typedef logic [2:0] req_t;

  localparam req_t REQ_ADD       = 3'd0;
  localparam req_t REQ_TICK      = 3'd1;
  localparam req_t REQ_TEMPO     = 3'd2;
  localparam req_t REQ_SET_LEN   = 3'd3;
  localparam req_t REQ_TRANSPORT = 3'd4;
  localparam req_t REQ_QUERY     = 3'd5;
  localparam req_t REQ_RESET     = 3'd6;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DIV    = 8'b0000_0010,
    ST_SUB    = 8'b0000_0100,
    ST_PREP   = 8'b0000_1000,
    ST_RSTART = 8'b0001_0000,
    ST_RND    = 8'b0010_0000,
    ST_FIN    = 8'b0100_0000,
    ST_TEMPO  = 8'b1000_0000
  } state_t;

  localparam logic [16:0] GRACE_SAMPLES = 17'd16;
  localparam int          SPB_MIN       = 8000;
  localparam int          SPB_MAX       = 100000;
  localparam logic [19:0] US_PER_S      = 20'd1000000;

endpackage

[sv/bcq_serdiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_serdiv
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcq_serdiv #(
  parameter int DW = 64,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] qd_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_r, qd_r[DW-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        qd_r   <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        qd_r  <= {qd_r[DW-2:0], ge};
        rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = qd_r;
  assign rem  = rem_r;

endmodule

[sv/beat_clock_quantizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beat_clock_quantizer
// Musical time base: sample position, MIDI tick and beat counters, tempo and
// transport, with quantization queries toward the next beat, bar and
// subdivision.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as beats on the in_ channel (valid/stall). Adds, ticks,
//   direct tempo sets, transport writes and timeline resets complete in the
//   cycle they are accepted. A tempo sync divides the scaled tick period by
//   one million in a bit-serial divider and stalls the input until it is done.
//   A query is the only request that returns a beat on the out_ channel.
//   It runs a serial remainder of the position, then a subdivision division
//   and a block rounding division before the result beat is offered, and
//   the input stalls until the result beat enters the output register.
//   The input side takes a new request as soon as the previous one is done,
//   even while a result still waits in the output register; a later query
//   holds its result until the receiver takes the earlier one.
//   The receiver may stall for any time; the result beat then holds.
//   Reset restores the default beat length and clears all counters, the
//   transport state, the beat flag and the output valid.
// ----------------------------------------------------------------------------
module beat_clock_quantizer #(
  parameter int SAMPLE_RATE_HZ   = 44100,
  parameter int TICKS_PER_BEAT   = 24,
  parameter int BEATS_PER_BAR_N  = 4,
  parameter int BLOCK_SAMPLES    = 128,
  parameter int DEFAULT_BEAT_LEN = 22050
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcq_pkg::req_t       in_req_type,
  input  logic [15:0]         in_sample_count,
  input  logic [19:0]         in_tick_period_us,
  input  logic [16:0]         in_beat_length_in,
  input  logic [1:0]          in_transport_in,
  input  logic [16:0]         in_subdivision_len,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_sample_position,
  output logic [31:0]         out_beat_number,
  output logic [4:0]          out_tick_in_beat,
  output logic [3:0]          out_beat_in_bar,
  output logic [31:0]         out_bar_number,
  output logic [16:0]         out_beat_length,
  output logic [1:0]          out_transport_state,
  output logic                out_beat_seen,
  output logic [16:0]         out_to_next_beat,
  output logic [17:0]         out_to_next_subdivision,
  output logic [18:0]         out_to_next_bar,
  output logic [1:0]          out_boundary_flags
);

  import bcq_pkg::*;

  localparam int BLW = 17 + $clog2(BEATS_PER_BAR_N);
  localparam int NW  = $clog2(BEATS_PER_BAR_N + 1);
  localparam int BKW = $clog2(BLOCK_SAMPLES + 1);
  localparam int TK  = TICKS_PER_BEAT * SAMPLE_RATE_HZ;
  localparam int KW  = $clog2(TK + 1);
  localparam int PW  = 20 + KW;

  state_t state_r, state_nxt;

  logic [63:0] position_r;
  logic [31:0] beats_r;
  logic [4:0]  tick_r;
  logic [16:0] spb_r;
  logic [1:0]  transport_r;
  logic        pending_r;

  logic [16:0] sub_r;
  logic        seen_r;
  logic [63:0] bstart_r;
  logic        flag_r;
  logic        last_r;
  logic        zero_r;
  logic [34:0] prod_r;
  logic [16:0] v_r;
  logic        out_valid_r;

  logic [63:0] o_pos_r;
  logic [31:0] o_beats_r, o_bar_r;
  logic [4:0]  o_tick_r;
  logic [3:0]  o_bib_r;
  logic [16:0] o_len_r, o_tobeat_r;
  logic [1:0]  o_tr_r, o_flags_r;
  logic        o_seen_r;
  logic [17:0] o_tosub_r;
  logic [18:0] o_tobar_r;

  logic in_acc, start_q, start_s, start_r, start_t;
  logic fin_go;

  // Serial divider results.
  logic            spb_done, bar_done, bn_done, pb_done, wi_done, rnd_done, tp_done;
  logic [63:0]     spb_quo, bar_quo;
  logic [16:0]     spb_rem;
  logic [BLW-1:0]  bar_rem;
  logic [31:0]     bn_quo;
  logic [NW-1:0]   bn_rem;
  logic [16:0]     pb_quo, pb_rem, wi_quo, wi_rem;
  logic [16:0]     rnd_quo;
  logic [BKW-1:0]  rnd_rem;
  logic [PW-1:0]   tp_quo;
  logic [19:0]     tp_rem;

  logic [BLW-1:0]  bar_len;
  logic [PW-1:0]   tempo_prod;
  logic [16:0]     within_beat;
  logic [17:0]     nidx;
  logic [16:0]     per_beat;
  logic [16:0]     v_nxt;
  logic [17:0]     rounded;
  logic [BLW-1:0]  bar_diff;
  logic [63:0]     pos_delta;

  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign start_q  = in_acc && (in_req_type == REQ_QUERY);
  assign start_t  = in_acc && (in_req_type == REQ_TEMPO);
  assign start_s  = (state_r == ST_DIV) && spb_done;
  assign start_r  = (state_r == ST_RSTART);
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign bar_len     = BLW'(spb_r) * BLW'(BEATS_PER_BAR_N);
  assign tempo_prod  = PW'(in_tick_period_us) * PW'(TK);
  assign within_beat = spb_rem;
  assign nidx        = 18'(wi_quo) + 18'd1;
  assign per_beat    = (pb_quo == '0) ? 17'd1 : pb_quo;
  assign v_nxt       = last_r ? (spb_r - within_beat) : 17'(prod_r - 35'(within_beat));
  assign rounded     = (rnd_rem == '0) ? 18'(v_r)
                       : 18'(v_r) + 18'(BLOCK_SAMPLES) - 18'(rnd_rem);
  assign bar_diff    = bar_len - bar_rem;
  assign pos_delta   = position_r - bstart_r;

  bcq_serdiv #(.DW(64), .VW(17)) u_mod_spb (
    .clk, .rst_n, .start(start_q), .dividend(position_r), .divisor(spb_r),
    .done(spb_done), .quo(spb_quo), .rem(spb_rem));

  bcq_serdiv #(.DW(64), .VW(BLW)) u_mod_bar (
    .clk, .rst_n, .start(start_q), .dividend(position_r), .divisor(bar_len),
    .done(bar_done), .quo(bar_quo), .rem(bar_rem));

  bcq_serdiv #(.DW(32), .VW(NW)) u_div_bar (
    .clk, .rst_n, .start(start_q), .dividend(beats_r),
    .divisor(NW'(BEATS_PER_BAR_N)), .done(bn_done), .quo(bn_quo), .rem(bn_rem));

  bcq_serdiv #(.DW(17), .VW(17)) u_per_beat (
    .clk, .rst_n, .start(start_s), .dividend(spb_r), .divisor(sub_r),
    .done(pb_done), .quo(pb_quo), .rem(pb_rem));

  bcq_serdiv #(.DW(17), .VW(17)) u_sub_idx (
    .clk, .rst_n, .start(start_s), .dividend(spb_rem), .divisor(sub_r),
    .done(wi_done), .quo(wi_quo), .rem(wi_rem));

  bcq_serdiv #(.DW(17), .VW(BKW)) u_round (
    .clk, .rst_n, .start(start_r), .dividend(v_nxt),
    .divisor(BKW'(BLOCK_SAMPLES)), .done(rnd_done), .quo(rnd_quo), .rem(rnd_rem));

  bcq_serdiv #(.DW(PW), .VW(20)) u_tempo (
    .clk, .rst_n, .start(start_t), .dividend(tempo_prod), .divisor(US_PER_S),
    .done(tp_done), .quo(tp_quo), .rem(tp_rem));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start_q) state_nxt = ST_DIV;
                 else if (start_t) state_nxt = ST_TEMPO;
      ST_DIV:    if (spb_done) state_nxt = ST_SUB;
      ST_SUB:    if (wi_done) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_RSTART;
      ST_RSTART: state_nxt = ST_RND;
      ST_RND:    if (rnd_done) state_nxt = ST_FIN;
      ST_FIN:    if (fin_go) state_nxt = ST_IDLE;
      ST_TEMPO:  if (tp_done) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Counters, tempo and transport; these hold while a query is in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      position_r  <= '0;
      beats_r     <= '0;
      tick_r      <= '0;
      spb_r       <= 17'(DEFAULT_BEAT_LEN);
      transport_r <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (in_acc) begin
        unique case (in_req_type)
          REQ_ADD: position_r <= position_r + 64'(in_sample_count);
          REQ_TICK: begin
            if (32'(tick_r) + 32'd1 >= 32'(TICKS_PER_BEAT)) begin
              tick_r    <= '0;
              beats_r   <= beats_r + 32'd1;
              pending_r <= 1'b1;
            end else begin
              tick_r <= tick_r + 5'd1;
            end
          end
          REQ_SET_LEN: if (in_beat_length_in != '0) spb_r <= in_beat_length_in;
          REQ_TRANSPORT: transport_r <= in_transport_in;
          REQ_QUERY: pending_r <= 1'b0;
          REQ_RESET: begin
            position_r  <= '0;
            beats_r     <= '0;
            tick_r      <= '0;
            spb_r       <= 17'(DEFAULT_BEAT_LEN);
            transport_r <= '0;
          end
          default: ;
        endcase
      end
      if ((state_r == ST_TEMPO) && tp_done &&
          (tp_quo >= PW'(SPB_MIN)) && (tp_quo <= PW'(SPB_MAX))) begin
        spb_r <= 17'(tp_quo);
      end
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    if (start_q) begin
      seen_r   <= pending_r;
      sub_r    <= (in_subdivision_len == '0) ? 17'd1 : in_subdivision_len;
      bstart_r <= 64'(beats_r) * 64'(spb_r);
    end
    if (state_r == ST_PREP) begin
      last_r <= nidx >= 18'(per_beat);
      zero_r <= (nidx >= 18'(per_beat)) ? (within_beat <= GRACE_SAMPLES)
                                          : (wi_rem <= GRACE_SAMPLES);
      prod_r <= 35'(nidx) * 35'(sub_r);
      flag_r <= (position_r >= bstart_r) && (pos_delta <= 64'(BLOCK_SAMPLES));
    end
    if (start_r) v_r <= v_nxt;
    if (fin_go) begin
      o_pos_r    <= position_r;
      o_beats_r  <= beats_r;
      o_tick_r   <= tick_r;
      o_bib_r    <= 4'(bn_rem);
      o_bar_r    <= bn_quo;
      o_len_r    <= spb_r;
      o_tr_r     <= transport_r;
      o_seen_r   <= seen_r;
      o_tobeat_r <= (within_beat <= GRACE_SAMPLES) ? 17'd0 : spb_r - within_beat;
      o_tosub_r  <= zero_r ? 18'd0 : rounded;
      o_tobar_r  <= (bar_rem <= BLW'(GRACE_SAMPLES)) ? 19'd0 : 19'(bar_diff);
      o_flags_r  <= {flag_r && (bn_rem == '0), flag_r};
    end
  end

  assign out_valid               = out_valid_r;
  assign out_sample_position     = o_pos_r;
  assign out_beat_number         = o_beats_r;
  assign out_tick_in_beat        = o_tick_r;
  assign out_beat_in_bar         = o_bib_r;
  assign out_bar_number          = o_bar_r;
  assign out_beat_length         = o_len_r;
  assign out_transport_state     = o_tr_r;
  assign out_beat_seen           = o_seen_r;
  assign out_to_next_beat        = o_tobeat_r;
  assign out_to_next_subdivision = o_tosub_r;
  assign out_to_next_bar         = o_tobar_r;
  assign out_boundary_flags      = o_flags_r;

endmodule

[sv/bcq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcq_checker
// Port-level checks of the beat clock quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "beat_clock_quantizer_assert.svh"

module bcq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input bcq_pkg::req_t in_req_type,
  input logic          out_valid,
  input logic          out_stall,
  input logic [63:0]   out_sample_position
);

  import bcq_pkg::*;

  // A stalled result beat stays valid and keeps its position.
  `BCQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_sample_position), "stalled result changed")

  // A query occupies the datapath, so the next cycle refuses input.
  `BCQ_ASSERT(a_query_busy, in_valid && !in_stall && in_req_type == REQ_QUERY |=> in_stall, "query did not block input")

  // A tempo sync runs the serial divider before the next request.
  `BCQ_ASSERT(a_tempo_busy, in_valid && !in_stall && in_req_type == REQ_TEMPO |=> in_stall, "tempo sync did not block input")

  // Reset drops any pending result.
  `BCQ_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind beat_clock_quantizer bcq_checker u_bcq_checker (.*);
